/* src/dtt_pkg.sv */
`timescale 1ns / 1ps

package dtt_pkg;

    // Grid geometry.
    localparam int TILES_WIDE = 20;
    localparam int TILES_HIGH = 13;
    localparam int TILE_SHIFT = 4;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int INDEX_W = 9;
    localparam int TC_W    = COORD_W - TILE_SHIFT;
    localparam int COL_W   = (TILES_WIDE > 1) ? $clog2(TILES_WIDE) : 1;
    localparam int ROW_W   = (TILES_HIGH > 1) ? $clog2(TILES_HIGH) : 1;

    localparam logic signed [TC_W-1:0] TC_WIDE    = TC_W'(TILES_WIDE);
    localparam logic signed [TC_W-1:0] TC_HIGH    = TC_W'(TILES_HIGH);
    localparam logic [COL_W-1:0]       COL_LAST   = COL_W'(TILES_WIDE - 1);
    localparam logic [ROW_W-1:0]       ROW_LAST   = ROW_W'(TILES_HIGH - 1);
    localparam logic [INDEX_W-1:0]     ROW_STRIDE = INDEX_W'(TILES_WIDE);

    typedef enum logic {
        FUNC_MARK = 1'b0,
        FUNC_TAKE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t                     func;
        logic signed [COORD_W-1:0] x_left;
        logic signed [COORD_W-1:0] y_top;
        logic signed [COORD_W-1:0] x_right;
        logic signed [COORD_W-1:0] y_bottom;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic               found;
        logic [INDEX_W-1:0] tile_index;
    } out_item_t;

    // Command to the shared row unit.
    typedef struct packed {
        logic             mark;
        logic [COL_W-1:0] c_lo;
        logic [COL_W-1:0] c_hi;
    } row_cmd_t;

    // Answer from the shared row unit.
    typedef struct packed {
        logic [TILES_WIDE-1:0] word;
        logic                  hit;
        logic [COL_W-1:0]      col;
    } row_res_t;

endpackage

/* src/dirty_tile_tracker.sv */
`timescale 1ns / 1ps

// Dirty tile tracker: one dirty bit per 16x16 pixel tile on a 20 by 13 tile
// grid, tiles numbered row-major. A mark transaction (func = 0) converts its
// signed pixel rectangle to tile coordinates with an arithmetic shift,
// rejects it (accepted = 0) when it lies wholly off the grid, and otherwise
// clips it and sets every covered tile. A take-next transaction (func = 1)
// clears the lowest-numbered dirty tile and returns its index with found = 1,
// or found = 0 and index 0 when the map is clean. Every input transaction
// yields exactly one result transaction. The map is stored as one register
// row per tile row and is clean after reset; a single row unit performs all
// updates, one tile row per clock. A mark walks the covered tile rows in
// turn (none when rejected or empty), and a take-next scans rows from the
// top until it finds a dirty tile or has checked the last row.
// The input is ready only while the block is idle; a finished result waits
// in the output register, so a new transaction can be taken while the
// previous result is still held, and only its completion waits for m_ready.
module dirty_tile_tracker import dtt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,

    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Sequencer state.
    state_t state_reg, state_next;

    // Work registers of the current transaction.
    logic [COL_W-1:0]   c_lo_reg, c_lo_next;
    logic [COL_W-1:0]   c_hi_reg, c_hi_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ROW_W-1:0]   row_hi_reg, row_hi_next;
    logic [INDEX_W-1:0] base_reg, base_next;
    out_item_t          res_reg, res_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // Dirty map, one register per tile row.
    logic [TILES_WIDE-1:0] map_reg [TILES_HIGH];
    logic                  row_we;

    row_cmd_t row_cmd;
    row_res_t row_res;

    // Decoding of the incoming rectangle. Dropping the low bits of a two's
    // complement value is an arithmetic shift, which rounds toward minus
    // infinity as required.
    logic signed [TC_W-1:0] c0_t, r0_t, c1_t, r1_t;
    logic                   reject;
    logic [COL_W-1:0]       c_lo_clip, c_hi_clip;
    logic [ROW_W-1:0]       r_lo_clip, r_hi_clip;
    logic                   rows_empty;
    logic                   accept_in;
    logic                   out_free;

    assign c0_t = s_data.x_left[COORD_W-1:TILE_SHIFT];
    assign r0_t = s_data.y_top[COORD_W-1:TILE_SHIFT];
    assign c1_t = s_data.x_right[COORD_W-1:TILE_SHIFT];
    assign r1_t = s_data.y_bottom[COORD_W-1:TILE_SHIFT];

    // Off-grid when the near corner lies past the grid or the far corner
    // lies before it.
    assign reject = (c0_t >= TC_WIDE) || (r0_t >= TC_HIGH) || c1_t[TC_W-1] || r1_t[TC_W-1];

    assign c_lo_clip = c0_t[TC_W-1] ? '0 : c0_t[COL_W-1:0];
    assign r_lo_clip = r0_t[TC_W-1] ? '0 : r0_t[ROW_W-1:0];
    assign c_hi_clip = (c1_t >= TC_WIDE) ? COL_LAST : c1_t[COL_W-1:0];
    assign r_hi_clip = (r1_t >= TC_HIGH) ? ROW_LAST : r1_t[ROW_W-1:0];

    // A rectangle inverted in rows touches nothing but is still accepted.
    // One inverted in columns yields an empty mask in the row unit.
    assign rows_empty = r_lo_clip > r_hi_clip;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Shared row unit.
    assign row_cmd.mark = (state_reg == ST_MARK);
    assign row_cmd.c_lo = c_lo_reg;
    assign row_cmd.c_hi = c_hi_reg;

    dtt_row_unit u_row_unit (
        .row_word (map_reg[row_reg]),
        .cmd      (row_cmd),
        .res      (row_res)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    if (s_data.func == FUNC_TAKE) begin
                        state_next = ST_SCAN;
                    end else if (reject || rows_empty) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (row_reg == row_hi_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (row_res.hit || (row_reg == ROW_LAST)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output controls.
    always_comb begin
        c_lo_next    = c_lo_reg;
        c_hi_next    = c_hi_reg;
        row_next     = row_reg;
        row_hi_next  = row_hi_reg;
        base_next    = base_reg;
        res_next     = res_reg;
        row_we       = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    c_lo_next           = c_lo_clip;
                    c_hi_next           = c_hi_clip;
                    row_hi_next         = r_hi_clip;
                    base_next           = '0;
                    res_next.found      = 1'b0;
                    res_next.tile_index = '0;
                    if (s_data.func == FUNC_TAKE) begin
                        row_next          = '0;
                        res_next.accepted = 1'b0;
                    end else begin
                        row_next          = r_lo_clip;
                        res_next.accepted = !reject;
                    end
                end
            end
            ST_MARK: begin
                row_we = 1'b1;
                if (row_reg != row_hi_reg) begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ST_SCAN: begin
                if (row_res.hit) begin
                    row_we              = 1'b1;
                    res_next.found      = 1'b1;
                    res_next.tile_index = base_reg + INDEX_W'(row_res.col);
                end else if (row_reg != ROW_LAST) begin
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + ROW_STRIDE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_lo_reg   <= c_lo_next;
        c_hi_reg   <= c_hi_next;
        row_reg    <= row_next;
        row_hi_reg <= row_hi_next;
        base_reg   <= base_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // The map is clean after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < TILES_HIGH; r++) begin
                map_reg[r] <= '0;
            end
        end else if (row_we) begin
            map_reg[row_reg] <= row_res.word;
        end
    end

`ifndef ASSERT_OFF
    // An accepted transaction always starts work.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("transaction accepted but sequencer stayed idle");

    // Marking never walks past the last clipped row.
    a_mark_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARK) |-> (row_reg <= row_hi_reg))
        else $error("mark row beyond clipped bottom row");

    // The running row base tracks the row counter during a scan.
    a_scan_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (base_reg == INDEX_W'(row_reg) * ROW_STRIDE))
        else $error("scan row base out of step with row counter");

    // A result only appears out of the completion state.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion state");
`endif

endmodule

/* src/dtt_row_unit.sv */
`timescale 1ns / 1ps

// Read-modify-write logic for one row of dirty bits.
module dtt_row_unit import dtt_pkg::*; (
    input  logic [TILES_WIDE-1:0] row_word,
    input  row_cmd_t              cmd,
    output row_res_t              res
);

    logic [TILES_WIDE-1:0] mask;
    logic [COL_W-1:0]      low_col;

    always_comb begin
        for (int c = 0; c < TILES_WIDE; c++) begin
            mask[c] = (COL_W'(c) >= cmd.c_lo) && (COL_W'(c) <= cmd.c_hi);
        end
    end

    // Lowest set bit of the row.
    always_comb begin
        low_col = '0;
        for (int c = TILES_WIDE - 1; c >= 0; c--) begin
            if (row_word[c]) begin
                low_col = COL_W'(c);
            end
        end
    end

    always_comb begin
        res.hit = |row_word;
        res.col = low_col;
        if (cmd.mark) begin
            res.word = row_word | mask;
        end else begin
            // Clearing the lowest set bit.
            res.word = row_word & (row_word - TILES_WIDE'(1));
        end
    end

endmodule
